// ----- rtl/drc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drc_pkg
// shared types and constants of the damage rectangle coalescer
// ----------------------------------------------------------------------------
package drc_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int EDGE_W      = 18;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic {
        ACT_ADD   = 1'b0,
        ACT_FLUSH = 1'b1
    } t_action;

    // classified request handed from front to back
    typedef struct packed {
        t_action            action;
        logic signed [EDGE_W-1:0] left;
        logic signed [EDGE_W-1:0] top;
        logic signed [EDGE_W-1:0] right;
        logic signed [EDGE_W-1:0] bottom;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FOLD,
        ST_APPEND,
        ST_FLUSH_RD,
        ST_FLUSH_OUT
    } t_state;

endpackage

// ----- rtl/damage_rectangle_coalescer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// damage_rectangle_coalescer
// merges damaged screen rectangles into a small table and emits it on flush
// ----------------------------------------------------------------------------
// add: scans one table entry per cycle through the registered read port; each
//   merge fetches the last entry, moves it into the merged slot and rereads
//   from entry 0; a full table is folded into the new rectangle
// flush: each rectangle is read from the table and registered at the output, one per ready cycle
// throughput: one request at a time in the back end, 2 entry queue in front
// reset: synchronous active low, clears queue, sequencer, output valid and entry count only
module damage_rectangle_coalescer
    import drc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: origin_x, origin_y, offset_x, offset_y, span_width, span_height
    input  logic [95:0] s_axis_tdata,
    // tuser: action
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: rect_left, rect_top, rect_width, rect_height, zero fill to 72 bits
    output logic [71:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    t_cmd        w_cmd;
    logic        w_cmd_valid, w_cmd_ready;
    logic [16:0] w_left, w_top;
    logic [17:0] w_width, w_height;

    // front: edge forming and request queue
    drc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_action      (s_axis_tuser),
        .i_origin_x    (s_axis_tdata[15:0]),
        .i_origin_y    (s_axis_tdata[31:16]),
        .i_offset_x    (s_axis_tdata[47:32]),
        .i_offset_y    (s_axis_tdata[63:48]),
        .i_span_width  (s_axis_tdata[79:64]),
        .i_span_height (s_axis_tdata[95:80]),
        .o_cmd_valid   (w_cmd_valid),
        .i_cmd_ready   (w_cmd_ready),
        .o_cmd         (w_cmd)
    );

    // back: table scan, merge, fold and flush
    drc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_left      (w_left),
        .o_top       (w_top),
        .o_width     (w_width),
        .o_height    (w_height),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, w_height, w_width, w_top, w_left};

endmodule

// ----- rtl/drc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drc_front
// forms edge rectangles, drops empty adds and queues requests
// ----------------------------------------------------------------------------
module drc_front
    import drc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic [15:0] i_origin_x,
    input  logic [15:0] i_origin_y,
    input  logic [15:0] i_offset_x,
    input  logic [15:0] i_offset_y,
    input  logic [15:0] i_span_width,
    input  logic [15:0] i_span_height,
    output logic        o_cmd_valid,
    input  logic        i_cmd_ready,
    output t_cmd        o_cmd
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [PTR_W:0]    r_cnt;
    t_cmd              w_cmd;
    logic              w_push, w_pop, w_keep;
    logic signed [EDGE_W-1:0] w_l, w_t;

    assign w_l = EDGE_W'(signed'(i_origin_x)) + EDGE_W'(signed'(i_offset_x));
    assign w_t = EDGE_W'(signed'(i_origin_y)) + EDGE_W'(signed'(i_offset_y));

    always_comb begin
        w_cmd.action = t_action'(i_action);
        w_cmd.left   = w_l;
        w_cmd.top    = w_t;
        w_cmd.right  = w_l + EDGE_W'(i_span_width);
        w_cmd.bottom = w_t + EDGE_W'(i_span_height);
    end

    // empty adds are accepted and dropped
    assign w_keep      = (i_action == ACT_FLUSH) ||
                         (i_span_width != 16'd0 && i_span_height != 16'd0);
    assign o_ready     = (r_cnt != (PTR_W+1)'(QUEUE_DEPTH));
    assign w_push      = i_valid && o_ready && w_keep;
    assign o_cmd_valid = (r_cnt != '0);
    assign w_pop       = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= PTR_W'((r_wr + 1'b1) % QUEUE_DEPTH);
            if (w_pop)  r_rd <= PTR_W'((r_rd + 1'b1) % QUEUE_DEPTH);
            r_cnt <= r_cnt + (PTR_W+1)'(w_push) - (PTR_W+1)'(w_pop);
        end
    end

endmodule

// ----- rtl/drc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drc_back
// rectangle table with merge scan, fold and flush sequencer
// ----------------------------------------------------------------------------
module drc_back
    import drc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    output logic        o_cmd_ready,
    input  t_cmd        i_cmd,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [16:0] o_left,
    output logic [16:0] o_top,
    output logic [17:0] o_width,
    output logic [17:0] o_height,
    output logic        o_last
);

    localparam int ROW_W = 4 * EDGE_W;

    logic [ROW_W-1:0] r_mem [TABLE_DEPTH];

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic signed [EDGE_W-1:0] r_l, r_t, r_r, r_b, n_l, n_t, n_r, n_b;
    logic [ROW_W-1:0]    r_rdata;
    logic                r_rd_ok, n_rd_ok;  // r_rdata belongs to r_idx
    logic                r_ovalid, n_ovalid;
    logic [16:0]         r_oleft, n_oleft, r_otop, n_otop;
    logic [17:0]         r_owidth, n_owidth, r_oheight, n_oheight;
    logic                r_olast, n_olast;

    logic [IDX_W-1:0]    w_raddr, w_waddr;
    logic                w_we;
    logic [ROW_W-1:0]    w_wdata;
    logic signed [EDGE_W-1:0] s_l, s_t, s_r, s_b;
    logic                w_touch;

    assign {s_l, s_t, s_r, s_b} = r_rdata;
    assign w_touch = (r_l <= s_r) && (s_l <= r_r) && (r_t <= s_b) && (s_t <= r_b);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_l = r_l; n_t = r_t; n_r = r_r; n_b = r_b;
        n_rd_ok   = 1'b0;
        n_ovalid  = r_ovalid;
        n_oleft   = r_oleft;
        n_otop    = r_otop;
        n_owidth  = r_owidth;
        n_oheight = r_oheight;
        n_olast   = r_olast;
        o_cmd_ready = 1'b0;
        w_raddr   = r_idx[IDX_W-1:0];
        w_we      = 1'b0;
        w_waddr   = r_idx[IDX_W-1:0];
        w_wdata   = r_rdata;

        if (r_ovalid && i_ready) n_ovalid = 1'b0;

        case (r_state)
            ST_IDLE: begin
                o_cmd_ready = 1'b1;
                w_raddr = '0;
                if (i_cmd_valid) begin
                    n_l = i_cmd.left; n_t = i_cmd.top;
                    n_r = i_cmd.right; n_b = i_cmd.bottom;
                    n_idx   = '0;
                    n_rd_ok = 1'b1;
                    if (i_cmd.action == ACT_FLUSH) begin
                        n_state = (r_count == '0) ? ST_IDLE : ST_FLUSH_OUT;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (r_idx >= r_count) begin
                    n_idx = '0;
                    n_rd_ok = 1'b1;
                    w_raddr = '0;
                    n_state = (r_count == CNT_W'(TABLE_DEPTH)) ? ST_FOLD : ST_APPEND;
                end else if (!r_rd_ok) begin
                    n_rd_ok = 1'b1;
                end else if (w_touch) begin
                    if (s_l < r_l) n_l = s_l;
                    if (s_t < r_t) n_t = s_t;
                    if (s_r > r_r) n_r = s_r;
                    if (s_b > r_b) n_b = s_b;
                    n_count = r_count - 1'b1;
                    // fetch last entry to move it into this slot
                    w_raddr = n_count[IDX_W-1:0];
                    n_state = ST_APPEND;
                    n_idx   = r_idx;
                    n_state = ST_FLUSH_RD; // reused as move step
                end else begin
                    n_idx   = r_idx + 1'b1;
                    w_raddr = IDX_W'(r_idx + 1'b1);
                    n_rd_ok = 1'b1;
                end
            end
            ST_FLUSH_RD: begin
                // move step: last entry now in r_rdata
                w_we    = 1'b1;
                w_waddr = r_idx[IDX_W-1:0];
                w_wdata = r_rdata;
                n_idx   = '0;
                n_state = ST_SCAN;
            end
            ST_FOLD: begin
                if (r_idx >= CNT_W'(TABLE_DEPTH)) begin
                    n_count = '0;
                    n_state = ST_APPEND;
                end else if (!r_rd_ok) begin
                    n_rd_ok = 1'b1;
                end else begin
                    if (s_l < r_l) n_l = s_l;
                    if (s_t < r_t) n_t = s_t;
                    if (s_r > r_r) n_r = s_r;
                    if (s_b > r_b) n_b = s_b;
                    n_idx   = r_idx + 1'b1;
                    w_raddr = IDX_W'(r_idx + 1'b1);
                    n_rd_ok = 1'b1;
                end
            end
            ST_APPEND: begin
                w_we    = 1'b1;
                w_waddr = r_count[IDX_W-1:0];
                w_wdata = {r_l, r_t, r_r, r_b};
                n_count = r_count + 1'b1;
                n_state = ST_IDLE;
            end
            ST_FLUSH_OUT: begin
                if (r_idx >= r_count) begin
                    n_count = '0;
                    n_state = ST_IDLE;
                end else if (!r_rd_ok) begin
                    n_rd_ok = 1'b1;
                end else if (!r_ovalid || i_ready) begin
                    n_ovalid  = 1'b1;
                    n_oleft   = s_l[16:0];
                    n_otop    = s_t[16:0];
                    n_owidth  = 18'(s_r - s_l);
                    n_oheight = 18'(s_b - s_t);
                    n_olast   = (r_idx + 1'b1 == r_count);
                    n_idx     = r_idx + 1'b1;
                    w_raddr   = IDX_W'(r_idx + 1'b1);
                    n_rd_ok   = 1'b1;
                end else begin
                    n_rd_ok = 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_rd_ok  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_rd_ok  <= n_rd_ok;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_l <= n_l; r_t <= n_t; r_r <= n_r; r_b <= n_b;
        r_oleft   <= n_oleft;
        r_otop    <= n_otop;
        r_owidth  <= n_owidth;
        r_oheight <= n_oheight;
        r_olast   <= n_olast;
    end

    assign o_valid  = r_ovalid;
    assign o_left   = r_oleft;
    assign o_top    = r_otop;
    assign o_width  = r_owidth;
    assign o_height = r_oheight;
    assign o_last   = r_olast;

endmodule
